[rtl/core/lpp_pkg.sv]
`default_nettype none

package lpp_pkg;

    // widths fixed by the item fields and registers
    localparam int OP_W      = 2;
    localparam int CHAN_W    = 3;
    localparam int PAT_W     = 8;
    localparam int LEVEL_W   = 3;
    localparam int DRIVE_W   = 5;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;

    // fixed channel roles and patterns
    localparam int          BEEP_CHANNEL  = 0;
    localparam int          ERROR_CHANNEL = 1;
    localparam int          BUTTON_LINES  = 2;
    localparam logic [7:0]  ERROR_PATTERN = 8'h55;
    localparam logic [7:0]  BEEP_PATTERN  = 8'h01;

    // register reset values
    localparam logic [TICK_W-1:0] BUTTON_TICKS_RST = 16'd50;
    localparam logic [TICK_W-1:0] SENSOR_TICKS_RST = 16'd1000;
    localparam logic [TICK_W-1:0] PERIOD_TICKS_RST = 16'd200;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_EVENT   = 2'd1,
        OP_LOAD    = 2'd2,
        OP_CAPTURE = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_TICKS = 2'd0,
        CFG_SENSOR_TICKS = 2'd1,
        CFG_PERIOD_TICKS = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t                operation;
        logic [CHAN_W-1:0]  channel;
        logic [PAT_W-1:0]   pattern;
        logic               repeat_req;
        logic [LEVEL_W-1:0] line_levels;
    } item_t;

endpackage

`default_nettype wire

[rtl/core/lpp_debounce.sv]
`default_nettype none

module lpp_debounce #(
    parameter int INPUT_LINES = 3
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             commit,
    input  wire lpp_pkg::item_t             item,
    input  wire [lpp_pkg::TICK_W-1:0]       button_ticks,
    input  wire [lpp_pkg::TICK_W-1:0]       sensor_ticks,
    output logic [INPUT_LINES-1:0]          stable_next,
    output logic [INPUT_LINES-1:0]          changed,
    output logic                            beep
);

    for (genvar i = 0; i < INPUT_LINES; i++) begin : g_line
        logic [lpp_pkg::TICK_W-1:0] cnt_reg;
        logic [lpp_pkg::TICK_W-1:0] cnt_next;
        logic [lpp_pkg::TICK_W-1:0] cnt_dec;
        logic [lpp_pkg::TICK_W-1:0] delay;
        logic                       armed_reg;
        logic                       armed_next;
        logic                       stable_reg;
        logic                       stable_nx;
        logic                       level;
        logic                       hit;
        logic                       chg;

        // raw level, lines past the level field read low
        if (i < lpp_pkg::LEVEL_W) begin : g_lv
            assign level = item.line_levels[i];
        end else begin : g_nolv
            assign level = 1'b0;
        end

        assign delay   = (i < lpp_pkg::BUTTON_LINES) ? button_ticks : sensor_ticks;
        assign hit     = (32'(item.channel) == i);
        assign cnt_dec = (cnt_reg != '0) ? cnt_reg - 1'b1 : '0;

        // per line next state
        always_comb
        begin
            cnt_next   = cnt_reg;
            armed_next = armed_reg;
            stable_nx  = stable_reg;
            chg        = 1'b0;
            case (item.operation)
                lpp_pkg::OP_TICK:
                begin
                    if (armed_reg)
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            armed_next = 1'b0;
                            if (level != stable_reg)
                            begin
                                stable_nx = level;
                                chg       = 1'b1;
                            end
                        end
                    end
                end
                lpp_pkg::OP_EVENT:
                begin
                    if (hit)
                    begin
                        armed_next = 1'b1;
                        cnt_next   = delay;
                    end
                end
                lpp_pkg::OP_CAPTURE:
                begin
                    stable_nx = level;
                    chg       = (level != stable_reg);
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg    <= '0;
                armed_reg  <= 1'b0;
                stable_reg <= 1'b0;
            end
            else if (commit)
            begin
                cnt_reg    <= cnt_next;
                armed_reg  <= armed_next;
                stable_reg <= stable_nx;
            end
        end

        assign stable_next[i] = stable_nx;
        assign changed[i]     = chg;
    end

    // a changed line on a tick loads a single beep
    assign beep = (item.operation == lpp_pkg::OP_TICK) && (changed != '0);

endmodule

`default_nettype wire

[rtl/core/lpp_pacer.sv]
`default_nettype none

module lpp_pacer #(
    parameter int OUTPUT_CHANNELS = 5,
    parameter int PATTERN_BITS    = 8
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             commit,
    input  wire lpp_pkg::item_t             item,
    input  wire                             beep,
    input  wire [lpp_pkg::TICK_W-1:0]       period_ticks,
    output logic [OUTPUT_CHANNELS-1:0]      level_next
);

    localparam int POS_W = $clog2(PATTERN_BITS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PATTERN_BITS - 1);

    for (genvar i = 0; i < OUTPUT_CHANNELS; i++) begin : g_chan
        logic [PATTERN_BITS-1:0]    pat_reg;
        logic [PATTERN_BITS-1:0]    pat_next;
        logic [PATTERN_BITS-1:0]    pat_eff;
        logic [POS_W-1:0]           pos_reg;
        logic [POS_W-1:0]           pos_next;
        logic [POS_W-1:0]           pos_eff;
        logic                       rep_reg;
        logic                       rep_next;
        logic                       rep_eff;
        logic [lpp_pkg::TICK_W-1:0] cnt_reg;
        logic [lpp_pkg::TICK_W-1:0] cnt_next;
        logic [lpp_pkg::TICK_W-1:0] cnt_dec;
        logic                       lvl_reg;
        logic                       lvl_next;
        logic                       beep_hit;
        logic                       load_hit;

        assign beep_hit = beep && (i == lpp_pkg::BEEP_CHANNEL);
        assign load_hit = (32'(item.channel) == i);

        // a beep from the debouncers lands before this tick's bit step
        assign pat_eff = beep_hit ? PATTERN_BITS'(lpp_pkg::BEEP_PATTERN) : pat_reg;
        assign pos_eff = beep_hit ? '0 : pos_reg;
        assign rep_eff = beep_hit ? 1'b0 : rep_reg;
        assign cnt_dec = (cnt_reg != '0) ? cnt_reg - 1'b1 : '0;

        // per channel next state
        always_comb
        begin
            pat_next = pat_reg;
            pos_next = pos_reg;
            rep_next = rep_reg;
            cnt_next = cnt_reg;
            lvl_next = lvl_reg;
            case (item.operation)
                lpp_pkg::OP_TICK:
                begin
                    pat_next = pat_eff;
                    pos_next = pos_eff;
                    rep_next = rep_eff;
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        cnt_next = period_ticks;
                        lvl_next = pat_eff[pos_eff];
                        if (pos_eff == LAST_POS)
                        begin
                            pos_next = '0;
                            if (!rep_eff)
                                pat_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_eff + 1'b1;
                        end
                    end
                end
                lpp_pkg::OP_LOAD:
                begin
                    if (load_hit)
                    begin
                        pat_next = PATTERN_BITS'(item.pattern);
                        pos_next = '0;
                        rep_next = item.repeat_req;
                    end
                end
                default:
                begin
                    pat_next = pat_reg;
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pat_reg <= (i == lpp_pkg::ERROR_CHANNEL) ?
                           PATTERN_BITS'(lpp_pkg::ERROR_PATTERN) : '0;
                rep_reg <= (i == lpp_pkg::ERROR_CHANNEL);
                pos_reg <= '0;
                cnt_reg <= '0;
                lvl_reg <= 1'b0;
            end
            else if (commit)
            begin
                pat_reg <= pat_next;
                pos_reg <= pos_next;
                rep_reg <= rep_next;
                cnt_reg <= cnt_next;
                lvl_reg <= lvl_next;
            end
        end

        assign level_next[i] = lvl_next;
    end

endmodule

`default_nettype wire

[rtl/core/led_pattern_pacer_with_debounce.sv]
`default_nettype none

// LED and beeper pattern pacer with input-line debounce.
// Input channel: in_valid / in_stall carry one item per beat (operation,
// channel, pattern, repeat_req, line_levels). Output channel: out_valid /
// out_stall carry exactly one result per item (drive_levels,
// debounced_levels, line_changed), in item order.
// Data path: an accepted item is registered in the input register, then its
// state update and result are computed combinationally and land in the
// result register once the result slot is free or being taken.
// Throughput: one item per cycle while out_stall is low, set by the single
// combinational pass from the input register to the result register; all
// timers are small parallel counters updated in that pass.
// Stall: while out_stall holds a waiting result, the input register keeps
// one more item and in_stall rises only once that register is also full.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 button
// debounce ticks, 1 sensor debounce ticks, 2 bit period ticks); write only
// while the block is idle.
// Reset: rst_n clears the pipe, loads the register defaults, and starts the
// error LED on its repeating 0x55 pattern with every other channel dark.
module led_pattern_pacer_with_debounce #(
    parameter int OUTPUT_CHANNELS = 5,
    parameter int INPUT_LINES     = 3,
    parameter int PATTERN_BITS    = 8
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire [lpp_pkg::OP_W-1:0]             operation,
    input  wire [lpp_pkg::CHAN_W-1:0]           channel,
    input  wire [lpp_pkg::PAT_W-1:0]            pattern,
    input  wire                                 repeat_req,
    input  wire [lpp_pkg::LEVEL_W-1:0]          line_levels,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [lpp_pkg::DRIVE_W-1:0]         drive_levels,
    output logic [lpp_pkg::LEVEL_W-1:0]         debounced_levels,
    output logic [lpp_pkg::LEVEL_W-1:0]         line_changed,
    input  wire                                 cfg_we,
    input  wire [lpp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [lpp_pkg::TICK_W-1:0]           cfg_data
);

    logic [lpp_pkg::TICK_W-1:0] button_ticks_reg;
    logic [lpp_pkg::TICK_W-1:0] sensor_ticks_reg;
    logic [lpp_pkg::TICK_W-1:0] period_ticks_reg;

    lpp_pkg::item_t             item_reg;
    logic                       item_valid_reg;
    logic                       item_valid_next;
    logic                       in_take;
    logic                       commit;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [lpp_pkg::DRIVE_W-1:0] drive_reg;
    logic [lpp_pkg::LEVEL_W-1:0] deb_reg;
    logic [lpp_pkg::LEVEL_W-1:0] chg_reg;

    logic [INPUT_LINES-1:0]     stable_next;
    logic [INPUT_LINES-1:0]     changed;
    logic                       beep;
    logic [OUTPUT_CHANNELS-1:0] level_next;
    logic [lpp_pkg::DRIVE_W-1:0] drive_next;
    logic [lpp_pkg::LEVEL_W-1:0] deb_next;
    logic [lpp_pkg::LEVEL_W-1:0] chg_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_ticks_reg <= lpp_pkg::BUTTON_TICKS_RST;
            sensor_ticks_reg <= lpp_pkg::SENSOR_TICKS_RST;
            period_ticks_reg <= lpp_pkg::PERIOD_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (lpp_pkg::cfg_idx_t'(cfg_index))
                lpp_pkg::CFG_BUTTON_TICKS: button_ticks_reg <= cfg_data;
                lpp_pkg::CFG_SENSOR_TICKS: sensor_ticks_reg <= cfg_data;
                lpp_pkg::CFG_PERIOD_TICKS: period_ticks_reg <= cfg_data;
                default:                   button_ticks_reg <= button_ticks_reg;
            endcase
        end
    end

    // handshake: item moves on when the result slot is free or being taken
    assign commit          = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall        = item_valid_reg && !commit;
    assign in_take         = in_valid && !in_stall;
    assign item_valid_next = in_take || (item_valid_reg && !commit);
    assign out_valid_next  = commit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation   <= lpp_pkg::op_t'(operation);
            item_reg.channel     <= channel;
            item_reg.pattern     <= pattern;
            item_reg.repeat_req  <= repeat_req;
            item_reg.line_levels <= line_levels;
        end
    end

    lpp_debounce #(
        .INPUT_LINES (INPUT_LINES)
    ) u_debounce (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (commit),
        .item         (item_reg),
        .button_ticks (button_ticks_reg),
        .sensor_ticks (sensor_ticks_reg),
        .stable_next  (stable_next),
        .changed      (changed),
        .beep         (beep)
    );

    lpp_pacer #(
        .OUTPUT_CHANNELS (OUTPUT_CHANNELS),
        .PATTERN_BITS    (PATTERN_BITS)
    ) u_pacer (
        .clk          (clk),
        .rst_n        (rst_n),
        .commit       (commit),
        .item         (item_reg),
        .beep         (beep),
        .period_ticks (period_ticks_reg),
        .level_next   (level_next)
    );

    // result fields show the lowest channels and lines only
    for (genvar i = 0; i < lpp_pkg::DRIVE_W; i++) begin : g_drive
        if (i < OUTPUT_CHANNELS) begin : g_on
            assign drive_next[i] = level_next[i];
        end else begin : g_off
            assign drive_next[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < lpp_pkg::LEVEL_W; i++) begin : g_deb
        if (i < INPUT_LINES) begin : g_on
            assign deb_next[i] = stable_next[i];
            assign chg_next[i] = changed[i];
        end else begin : g_off
            assign deb_next[i] = 1'b0;
            assign chg_next[i] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            drive_reg <= drive_next;
            deb_reg   <= deb_next;
            chg_reg   <= chg_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign drive_levels     = drive_reg;
    assign debounced_levels = deb_reg;
    assign line_changed     = chg_reg;

    // checks on the pipe and the update logic
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid)
        else $error("committed item gave no result");

    a_no_change_on_event: assert property (@(posedge clk) disable iff (!rst_n)
        commit && (item_reg.operation == lpp_pkg::OP_EVENT ||
                   item_reg.operation == lpp_pkg::OP_LOAD) |-> chg_next == '0)
        else $error("line change reported on an event or load");

    a_beep_on_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        beep |-> item_reg.operation == lpp_pkg::OP_TICK)
        else $error("beep raised outside a tick");

endmodule

`default_nettype wire

[verif/led_pattern_pacer_with_debounce_test.sv]
`timescale 1ns / 100ps

// one result beat: drive levels, debounced levels and change flags
typedef struct packed {
    logic [lpp_pkg::DRIVE_W-1:0] drive;
    logic [lpp_pkg::LEVEL_W-1:0] held;
    logic [lpp_pkg::LEVEL_W-1:0] changed;
} levels_t;

// tracks pacer and debounce state and holds the levels each beat should produce
class drive_level_board;
    logic [lpp_pkg::TICK_W-1:0] button_ticks;
    logic [lpp_pkg::TICK_W-1:0] sensor_ticks;
    logic [lpp_pkg::TICK_W-1:0] period_ticks;
    logic [lpp_pkg::PAT_W-1:0]  pat_store [5];
    logic [2:0]                 bit_pos [5];
    logic [lpp_pkg::TICK_W-1:0] bit_cnt [5];
    logic [4:0]                 rep_flag;
    logic [4:0]                 drive;
    logic [lpp_pkg::TICK_W-1:0] settle_cnt [3];
    logic [2:0]                 armed;
    logic [2:0]                 held;
    levels_t                    awaited [$];
    int                         errors;

    // state right after reset: error led repeating its pattern, all else dark
    function new();
        button_ticks = lpp_pkg::BUTTON_TICKS_RST;
        sensor_ticks = lpp_pkg::SENSOR_TICKS_RST;
        period_ticks = lpp_pkg::PERIOD_TICKS_RST;
        foreach (pat_store[i])
        begin
            pat_store[i] = '0;
            bit_pos[i]   = '0;
            bit_cnt[i]   = '0;
        end
        rep_flag = '0;
        drive    = '0;
        pat_store[lpp_pkg::ERROR_CHANNEL] = lpp_pkg::ERROR_PATTERN;
        rep_flag[lpp_pkg::ERROR_CHANNEL]  = 1'b1;
        foreach (settle_cnt[i])
            settle_cnt[i] = '0;
        armed  = '0;
        held   = '0;
        errors = 0;
    endfunction

    function void set_reg(lpp_pkg::cfg_idx_t idx, logic [lpp_pkg::TICK_W-1:0] val);
        case (idx)
            lpp_pkg::CFG_BUTTON_TICKS: button_ticks = val;
            lpp_pkg::CFG_SENSOR_TICKS: sensor_ticks = val;
            lpp_pkg::CFG_PERIOD_TICKS: period_ticks = val;
            default: ;
        endcase
    endfunction

    // a load restarts the pattern at bit zero but leaves the timer phase alone
    function void load(int ch, logic [lpp_pkg::PAT_W-1:0] pat, logic rep);
        if (ch < 5)
        begin
            pat_store[ch] = pat;
            bit_pos[ch]   = '0;
            rep_flag[ch]  = rep;
        end
    endfunction

    function void note_item(lpp_pkg::item_t it);
        levels_t want;
        int      ch;
        ch           = int'(it.channel);
        want.changed = '0;
        case (it.operation)
            lpp_pkg::OP_TICK:
            begin
                // debouncers first, so a beep can show on this same tick
                foreach (settle_cnt[i])
                begin
                    if (armed[i])
                    begin
                        if (settle_cnt[i] != 0)
                            settle_cnt[i]--;
                        if (settle_cnt[i] == 0)
                        begin
                            if (it.line_levels[i] != held[i])
                            begin
                                held[i]         = it.line_levels[i];
                                want.changed[i] = 1'b1;
                                load(lpp_pkg::BEEP_CHANNEL, lpp_pkg::BEEP_PATTERN, 1'b0);
                            end
                            armed[i] = 1'b0;
                        end
                    end
                end
                // then each pacer shifts out its next bit when its period ends
                foreach (bit_cnt[i])
                begin
                    if (bit_cnt[i] != 0)
                        bit_cnt[i]--;
                    if (bit_cnt[i] == 0)
                    begin
                        bit_cnt[i] = period_ticks;
                        drive[i]   = pat_store[i][bit_pos[i]];
                        if (bit_pos[i] == 3'd7)
                        begin
                            bit_pos[i] = '0;
                            if (!rep_flag[i])
                                pat_store[i] = '0;
                        end
                        else
                            bit_pos[i]++;
                    end
                end
            end
            lpp_pkg::OP_EVENT:
            begin
                // an event restarts the countdown with the full delay
                if (ch < 3)
                begin
                    armed[ch]      = 1'b1;
                    settle_cnt[ch] = (ch < lpp_pkg::BUTTON_LINES) ? button_ticks : sensor_ticks;
                end
            end
            lpp_pkg::OP_LOAD:
                load(ch, it.pattern, it.repeat_req);
            lpp_pkg::OP_CAPTURE:
            begin
                // capture neither beeps nor disarms
                want.changed = it.line_levels ^ held;
                held         = it.line_levels;
            end
            default: ;
        endcase
        want.drive = drive;
        want.held  = held;
        awaited.push_back(want);
    endfunction

    function void mismatch(string field, logic [4:0] want, logic [4:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, field, want, got);
    endfunction

    function void check_levels(logic [lpp_pkg::DRIVE_W-1:0] drv,
                               logic [lpp_pkg::LEVEL_W-1:0] deb,
                               logic [lpp_pkg::LEVEL_W-1:0] chg);
        levels_t want;
        if (awaited.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual 'h%0h 'h%0h 'h%0h",
                     $time, drv, deb, chg);
            return;
        end
        want = awaited.pop_front();
        if (drv !== want.drive)
            mismatch("drive_levels", want.drive, drv);
        if (deb !== want.held)
            mismatch("debounced_levels", 5'(want.held), 5'(deb));
        if (chg !== want.changed)
            mismatch("line_changed", 5'(want.changed), 5'(chg));
    endfunction
endclass

module led_pattern_pacer_with_debounce_test;

    localparam int IDLE_LIMIT = 4000;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [lpp_pkg::OP_W-1:0]          operation;
    logic [lpp_pkg::CHAN_W-1:0]        channel;
    logic [lpp_pkg::PAT_W-1:0]         pattern;
    logic                              repeat_req;
    logic [lpp_pkg::LEVEL_W-1:0]       line_levels;
    logic                              out_valid;
    logic                              out_stall;
    logic [lpp_pkg::DRIVE_W-1:0]       drive_levels;
    logic [lpp_pkg::LEVEL_W-1:0]       debounced_levels;
    logic [lpp_pkg::LEVEL_W-1:0]       line_changed;
    logic                              cfg_we;
    logic [lpp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [lpp_pkg::TICK_W-1:0]        cfg_data;

    drive_level_board                  board;
    int unsigned                       quiet_cycles;
    int unsigned                       burst_left = 0;
    logic [lpp_pkg::LEVEL_W-1:0]       line_hold = '0;

    led_pattern_pacer_with_debounce u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .channel          (channel),
        .pattern          (pattern),
        .repeat_req       (repeat_req),
        .line_levels      (line_levels),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive_levels     (drive_levels),
        .debounced_levels (debounced_levels),
        .line_changed     (line_changed),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // result beats checked as they leave the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_levels(drive_levels, debounced_levels, line_changed);
    end

    // watchdog: too long with no beat on either side ends the run
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // receiver stalls in stretches: none, light, heavy
    initial
    begin
        int unsigned mode;
        int unsigned span;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall = 1'b0;
                    1: out_stall = ($urandom_range(0, 2) == 0);
                    default: out_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic lpp_pkg::item_t beat_of(lpp_pkg::op_t op,
                                               logic [lpp_pkg::CHAN_W-1:0] ch,
                                               logic [lpp_pkg::PAT_W-1:0] pat,
                                               logic rep,
                                               logic [lpp_pkg::LEVEL_W-1:0] lv);
        lpp_pkg::item_t it;
        it.operation   = op;
        it.channel     = ch;
        it.pattern     = pat;
        it.repeat_req  = rep;
        it.line_levels = lv;
        return it;
    endfunction

    // mostly ticks over held line levels, with events that sometimes flip a line first
    function automatic lpp_pkg::item_t pick_item(int unsigned ev_pct);
        lpp_pkg::item_t it;
        int unsigned    roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0)
            line_hold = lpp_pkg::LEVEL_W'($urandom_range(0, 7));
        it.operation  = lpp_pkg::OP_TICK;
        it.channel    = lpp_pkg::CHAN_W'($urandom_range(0, 4));
        it.pattern    = lpp_pkg::PAT_W'($urandom_range(0, 255));
        it.repeat_req = ($urandom_range(0, 1) == 1);
        if ($urandom_range(0, 9) == 0)
            it.pattern = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        if (roll < ev_pct)
        begin
            it.operation = lpp_pkg::OP_EVENT;
            if ($urandom_range(0, 9) == 0)
                it.channel = lpp_pkg::CHAN_W'($urandom_range(3, 7));
            else
            begin
                it.channel = lpp_pkg::CHAN_W'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 1)
                    line_hold[it.channel] = ~line_hold[it.channel];
            end
        end
        else if (roll < ev_pct + 16)
        begin
            it.operation = lpp_pkg::OP_LOAD;
            if ($urandom_range(0, 9) == 0)
                it.channel = lpp_pkg::CHAN_W'($urandom_range(5, 7));
        end
        else if (roll < ev_pct + 22)
            it.operation = lpp_pkg::OP_CAPTURE;
        it.line_levels = (it.operation == lpp_pkg::OP_CAPTURE) ?
                         lpp_pkg::LEVEL_W'($urandom_range(0, 7)) : line_hold;
        return it;
    endfunction

    // offer one beat and hold it until accepted; returns at a falling edge
    task automatic send_item(lpp_pkg::item_t it);
        operation   = it.operation;
        channel     = it.channel;
        pattern     = it.pattern;
        repeat_req  = it.repeat_req;
        line_levels = it.line_levels;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(it);
        @(negedge clk);
    endtask

    // bursts of random length, random gaps carrying junk payload
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap)
                begin
                    {operation, channel, pattern, repeat_req, line_levels} = 17'($urandom);
                    @(negedge clk);
                end
            end
        end
        burst_left--;
    endtask

    // hold off until every result beat is back and the pipe is quiet
    task automatic settle();
        in_valid = 1'b0;
        while (board.awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_regs(logic [lpp_pkg::TICK_W-1:0] btn,
                              logic [lpp_pkg::TICK_W-1:0] sen,
                              logic [lpp_pkg::TICK_W-1:0] per);
        lpp_pkg::cfg_idx_t           idx [4];
        logic [lpp_pkg::TICK_W-1:0]  val [4];
        idx = '{lpp_pkg::CFG_BUTTON_TICKS, lpp_pkg::CFG_SENSOR_TICKS,
                lpp_pkg::CFG_PERIOD_TICKS, lpp_pkg::CFG_UNUSED};
        val = '{btn, sen, per, lpp_pkg::TICK_W'($urandom)};
        cfg_we = 1'b1;
        foreach (idx[i])
        begin
            cfg_index = idx[i];
            cfg_data  = val[i];
            board.set_reg(idx[i], val[i]);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    initial
    begin
        int unsigned btn_tab [7];
        int unsigned sen_tab [7];
        int unsigned per_tab [7];
        int unsigned len_tab [7];
        int unsigned ev_tab  [7];

        btn_tab = '{50, 0, 3, 65535, 1, 5, 2};
        sen_tab = '{1000, 0, 7, 65535, 2, 12, 0};
        per_tab = '{200, 1, 2, 65535, 1, 3, 4};
        len_tab = '{220, 180, 180, 80, 180, 180, 200};
        ev_tab  = '{3, 12, 12, 6, 12, 12, 12};

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = '0;
        channel     = '0;
        pattern     = '0;
        repeat_req  = 1'b0;
        line_levels = '0;
        cfg_we      = 1'b0;
        cfg_index   = lpp_pkg::CFG_BUTTON_TICKS;
        cfg_data    = '0;
        board       = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed beats at the reset settings
        send_item(beat_of(lpp_pkg::OP_TICK, 3'd0, 8'h00, 1'b0, 3'b000));
        send_item(beat_of(lpp_pkg::OP_TICK, 3'd0, 8'h00, 1'b0, 3'b000));
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd0, 8'hFF, 1'b1, 3'b000));
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd4, 8'h00, 1'b0, 3'b000));
        // loads beyond the last channel are dropped
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd5, 8'hAA, 1'b1, 3'b000));
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd7, 8'hFF, 1'b0, 3'b111));
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd3, 8'h81, 1'b0, 3'b000));
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd2, 8'h7E, 1'b1, 3'b000));
        send_item(beat_of(lpp_pkg::OP_TICK, 3'd0, 8'h00, 1'b0, 3'b111));
        send_item(beat_of(lpp_pkg::OP_CAPTURE, 3'd0, 8'h00, 1'b0, 3'b111));
        send_item(beat_of(lpp_pkg::OP_CAPTURE, 3'd0, 8'h00, 1'b0, 3'b000));
        send_item(beat_of(lpp_pkg::OP_EVENT, 3'd0, 8'h00, 1'b0, 3'b001));
        send_item(beat_of(lpp_pkg::OP_EVENT, 3'd1, 8'h00, 1'b0, 3'b011));
        send_item(beat_of(lpp_pkg::OP_EVENT, 3'd2, 8'h00, 1'b0, 3'b111));
        // events on lines that do not exist
        send_item(beat_of(lpp_pkg::OP_EVENT, 3'd3, 8'h00, 1'b0, 3'b111));
        send_item(beat_of(lpp_pkg::OP_EVENT, 3'd7, 8'h00, 1'b0, 3'b111));
        // capture while debouncers are armed
        send_item(beat_of(lpp_pkg::OP_CAPTURE, 3'd0, 8'h00, 1'b0, 3'b101));
        send_item(beat_of(lpp_pkg::OP_TICK, 3'd0, 8'h00, 1'b0, 3'b010));
        // event during a countdown restarts it
        send_item(beat_of(lpp_pkg::OP_EVENT, 3'd0, 8'h00, 1'b0, 3'b010));
        send_item(beat_of(lpp_pkg::OP_LOAD, 3'd1, 8'hFF, 1'b0, 3'b000));
        send_item(beat_of(lpp_pkg::OP_TICK, 3'd0, 8'h00, 1'b0, 3'b111));
        send_item(beat_of(lpp_pkg::OP_TICK, 3'd0, 8'h00, 1'b0, 3'b000));

        // random phases, each under its own register settings
        for (int ph = 0; ph < 7; ph++)
        begin
            settle();
            if (ph != 0)
                write_regs(lpp_pkg::TICK_W'(btn_tab[ph]), lpp_pkg::TICK_W'(sen_tab[ph]),
                           lpp_pkg::TICK_W'(per_tab[ph]));
            for (int n = 0; n < len_tab[ph]; n++)
            begin
                if (ph == 2 && n == len_tab[ph] / 2)
                    settle();
                pace();
                send_item(pick_item(ev_tab[ph]));
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[files.f]
rtl/core/lpp_pkg.sv
rtl/core/lpp_debounce.sv
rtl/core/lpp_pacer.sv
rtl/core/led_pattern_pacer_with_debounce.sv
verif/led_pattern_pacer_with_debounce_test.sv
